### rtl/svt_pkg.sv
// Types, constants and helpers shared by the sprite quad vertex transform.
package svt_pkg;

  typedef logic signed [23:0] coord_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] rect_width;
    logic signed [23:0] rect_height;
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [11:0]        src_width;
    logic [11:0]        src_height;
    logic [12:0]        tex_width;
    logic [12:0]        tex_height;
    logic               affine_mode;
  } item_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [15:0]        angle;
    logic signed [23:0] rot_cx;
    logic signed [23:0] rot_cy;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_ANGLE    = 3'd0,
    REG_ROT_CX   = 3'd1,
    REG_ROT_CY   = 3'd2,
    REG_SCALE_X  = 3'd3,
    REG_SCALE_Y  = 3'd4,
    REG_ORIGIN_X = 3'd5,
    REG_ORIGIN_Y = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_e;

  typedef struct packed {
    coord_t [3:0] vx;
    coord_t [3:0] vy;
  } verts_t;

  typedef struct packed {
    logic [28:0] num;
    logic [13:0] den;
  } div_in_t;

  typedef struct packed {
    verts_t      verts;
    logic [15:0] u0;
    logic [15:0] u1;
    logic [15:0] v0;
    logic [15:0] v1;
  } quad_t;

  localparam logic [14:0] SIN_A      = 15'd25736;
  localparam logic [13:0] SIN_B      = 14'd10512;
  localparam logic [10:0] SIN_C      = 11'd1160;
  localparam logic [14:0] QUARTER    = 15'd16384;
  localparam int          DIV_BITS   = 16;
  localparam logic [15:0] UV_MAX     = 16'hFFFF;
  localparam logic [15:0] SCALE_ONE  = 16'd256;

  function automatic coord_t sat24(input logic signed [39:0] v);
    if (v > 40'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -40'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

### rtl/svt_front.sv
// Front pipeline: takes rectangles, builds sine and cosine, corner positions and divider operands.
module svt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  svt_pkg::item_t   item,
  input  svt_pkg::cfg_t    cfg,
  output logic             out_valid,
  output svt_pkg::verts_t  verts,
  output svt_pkg::div_in_t div_in [4]
);

  svt_pkg::item_t it [6];
  logic [5:0] vld;

  logic signed [40:0] mx0, mx1, my0, my1;
  logic [15:0] z2a2, z2b2, z2a3, z2b3;
  logic signed [35:0] lx0, lx1, ly0, ly1;
  logic signed [35:0] lx0_4, lx1_4, ly0_4, ly1_4, lx0_5, lx1_5, ly0_5, ly1_5;
  logic [13:0] inner_a, inner_b;
  logic [15:0] poly_a, poly_b;
  logic signed [15:0] sn, cs;
  logic signed [51:0] p_lx0c, p_lx1c, p_lx0s, p_lx1s, p_ly0c, p_ly1c, p_ly0s, p_ly1s;

  logic signed [23:0] rcx, rcy, sox, soy;
  logic signed [15:0] scx, scy;
  logic [14:0] za, zb;
  logic [1:0]  quad;

  assign rcx  = cfg.rot_cx;
  assign rcy  = cfg.rot_cy;
  assign sox  = cfg.origin_x;
  assign soy  = cfg.origin_y;
  assign scx  = cfg.scale_x;
  assign scy  = cfg.scale_y;
  assign za   = {1'b0, cfg.angle[13:0]};
  assign zb   = svt_pkg::QUARTER - za;
  assign quad = cfg.angle[15:14];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    it[0] <= item;
    for (int i = 1; i < 6; i++) begin
      it[i] <= it[i-1];
    end
  end

  // scale products and z squared
  logic signed [24:0] dx0, dx1, dy0, dy1;
  logic [29:0] zsa, zsb;
  always_comb begin
    dx0 = -25'(rcx);
    dx1 = 25'(it[0].rect_width) - 25'(rcx);
    dy0 = -25'(rcy);
    dy1 = 25'(it[0].rect_height) - 25'(rcy);
    zsa = 30'(za) * 30'(za);
    zsb = 30'(zb) * 30'(zb);
  end

  always_ff @(posedge clk) begin
    mx0  <= dx0 * scx;
    mx1  <= dx1 * scx;
    my0  <= dy0 * scy;
    my1  <= dy1 * scy;
    z2a2 <= zsa[29:14];
    z2b2 <= zsb[29:14];
  end

  // round scaled corners, inner polynomial term
  logic signed [41:0] rx0, rx1, ry0, ry1;
  logic [26:0] ica, icb;
  always_comb begin
    rx0 = 42'(mx0) + 42'sd128;
    rx1 = 42'(mx1) + 42'sd128;
    ry0 = 42'(my0) + 42'sd128;
    ry1 = 42'(my1) + 42'sd128;
    ica = 27'(z2a2) * 27'(svt_pkg::SIN_C);
    icb = 27'(z2b2) * 27'(svt_pkg::SIN_C);
  end

  always_ff @(posedge clk) begin
    lx0     <= 36'($signed(rx0[41:8])) + 36'(sox) - 36'(rcx);
    lx1     <= 36'($signed(rx1[41:8])) + 36'(sox) - 36'(rcx);
    ly0     <= 36'($signed(ry0[41:8])) + 36'(soy) - 36'(rcy);
    ly1     <= 36'($signed(ry1[41:8])) + 36'(soy) - 36'(rcy);
    inner_a <= svt_pkg::SIN_B - 14'(ica[26:14]);
    inner_b <= svt_pkg::SIN_B - 14'(icb[26:14]);
    z2a3    <= z2a2;
    z2b3    <= z2b2;
  end

  // outer polynomial term
  logic [29:0] pa, pb;
  always_comb begin
    pa = 30'(z2a3) * 30'(inner_a);
    pb = 30'(z2b3) * 30'(inner_b);
  end

  always_ff @(posedge clk) begin
    poly_a <= 16'(svt_pkg::SIN_A) - pa[29:14];
    poly_b <= 16'(svt_pkg::SIN_A) - pb[29:14];
    lx0_4  <= lx0;
    lx1_4  <= lx1;
    ly0_4  <= ly0;
    ly1_4  <= ly1;
  end

  // final sine terms, fold quadrant
  logic [30:0] sa, sb;
  logic signed [15:0] va, vb;
  always_comb begin
    sa = 31'(za) * 31'(poly_a);
    sb = 31'(zb) * 31'(poly_b);
    va = 16'(sa[30:14]);
    vb = 16'(sb[30:14]);
  end

  always_ff @(posedge clk) begin
    case (quad)
      2'd0:    begin sn <= va;  cs <= vb;  end
      2'd1:    begin sn <= vb;  cs <= -va; end
      2'd2:    begin sn <= -va; cs <= -vb; end
      default: begin sn <= -vb; cs <= va;  end
    endcase
    lx0_5 <= lx0_4;
    lx1_5 <= lx1_4;
    ly0_5 <= ly0_4;
    ly1_5 <= ly1_4;
  end

  // rotation products
  always_ff @(posedge clk) begin
    p_lx0c <= lx0_5 * cs;
    p_lx1c <= lx1_5 * cs;
    p_lx0s <= lx0_5 * sn;
    p_lx1s <= lx1_5 * sn;
    p_ly0c <= ly0_5 * cs;
    p_ly1c <= ly1_5 * cs;
    p_ly0s <= ly0_5 * sn;
    p_ly1s <= ly1_5 * sn;
  end

  // combine, offset, saturate, pick plain or affine
  logic signed [25:0] ox, oy;
  logic signed [24:0] pxw, pyh;
  logic signed [52:0] sx [4];
  logic signed [52:0] sy [4];
  svt_pkg::coord_t ax [4];
  svt_pkg::coord_t ay [4];
  logic [12:0] tw, th, tu1, tv1;
  always_comb begin
    ox  = 26'(it[5].pos_x) + 26'(rcx) - 26'sd128;
    oy  = 26'(it[5].pos_y) + 26'(rcy) - 26'sd128;
    pxw = 25'(it[5].pos_x) + 25'(it[5].rect_width);
    pyh = 25'(it[5].pos_y) + 25'(it[5].rect_height);
    sx[0] = 53'(p_lx0c) - 53'(p_ly0s) + 53'sd8192;
    sx[1] = 53'(p_lx1c) - 53'(p_ly0s) + 53'sd8192;
    sx[2] = 53'(p_lx1c) - 53'(p_ly1s) + 53'sd8192;
    sx[3] = 53'(p_lx0c) - 53'(p_ly1s) + 53'sd8192;
    sy[0] = 53'(p_lx0s) + 53'(p_ly0c) + 53'sd8192;
    sy[1] = 53'(p_lx1s) + 53'(p_ly0c) + 53'sd8192;
    sy[2] = 53'(p_lx1s) + 53'(p_ly1c) + 53'sd8192;
    sy[3] = 53'(p_lx0s) + 53'(p_ly1c) + 53'sd8192;
    for (int k = 0; k < 4; k++) begin
      ax[k] = svt_pkg::sat24(40'($signed(sx[k][52:14])) + 40'(ox));
      ay[k] = svt_pkg::sat24(40'($signed(sy[k][52:14])) + 40'(oy));
    end
    tw  = (it[5].tex_width == '0) ? 13'd1 : it[5].tex_width;
    th  = (it[5].tex_height == '0) ? 13'd1 : it[5].tex_height;
    tu1 = 13'(it[5].src_x) + 13'(it[5].src_width);
    tv1 = 13'(it[5].src_y) + 13'(it[5].src_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[5];
    end
  end

  always_ff @(posedge clk) begin
    if (it[5].affine_mode) begin
      for (int k = 0; k < 4; k++) begin
        verts.vx[k] <= ax[k];
        verts.vy[k] <= ay[k];
      end
    end else begin
      verts.vx[0] <= it[5].pos_x;
      verts.vx[1] <= svt_pkg::sat24(40'(pxw));
      verts.vx[2] <= svt_pkg::sat24(40'(pxw));
      verts.vx[3] <= it[5].pos_x;
      verts.vy[0] <= it[5].pos_y;
      verts.vy[1] <= it[5].pos_y;
      verts.vy[2] <= svt_pkg::sat24(40'(pyh));
      verts.vy[3] <= svt_pkg::sat24(40'(pyh));
    end
    div_in[0].num <= {1'b0, it[5].src_x, 15'd0} + 29'(tw);
    div_in[1].num <= {tu1, 15'd0} + 29'(tw);
    div_in[2].num <= {1'b0, it[5].src_y, 15'd0} + 29'(th);
    div_in[3].num <= {tv1, 15'd0} + 29'(th);
    div_in[0].den <= {tw, 1'b0};
    div_in[1].den <= {tw, 1'b0};
    div_in[2].den <= {th, 1'b0};
    div_in[3].den <= {th, 1'b0};
  end

endmodule

### rtl/svt_texdiv.sv
// Pipelined restoring dividers for the four texture coordinates, one quotient bit per stage.
module svt_texdiv (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  svt_pkg::verts_t  verts,
  input  svt_pkg::div_in_t div_in [4],
  output logic             out_valid,
  output svt_pkg::quad_t   quad
);

  localparam int NS = svt_pkg::DIV_BITS + 1;

  logic [NS-1:0]   vld;
  svt_pkg::verts_t vt  [NS];
  logic [29:0]     rem [NS][4];
  logic [13:0]     den [NS][4];
  logic [15:0]     quo [NS][4];
  logic            sat [NS][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    vt[0] <= verts;
    for (int l = 0; l < 4; l++) begin
      rem[0][l] <= 30'(div_in[l].num);
      den[0][l] <= div_in[l].den;
      quo[0][l] <= '0;
      sat[0][l] <= 30'(div_in[l].num) >= {div_in[l].den, 16'd0};
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_stage
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [29:0] shifted;
      assign shifted = {16'd0, den[j-1][l]} << (svt_pkg::DIV_BITS - j);
      always_ff @(posedge clk) begin
        den[j][l] <= den[j-1][l];
        sat[j][l] <= sat[j-1][l];
        if (rem[j-1][l] >= shifted) begin
          rem[j][l] <= rem[j-1][l] - shifted;
          quo[j][l] <= quo[j-1][l] | (16'd1 << (svt_pkg::DIV_BITS - j));
        end else begin
          rem[j][l] <= rem[j-1][l];
          quo[j][l] <= quo[j-1][l];
        end
      end
    end
    always_ff @(posedge clk) begin
      vt[j] <= vt[j-1];
    end
  end

  assign out_valid  = vld[NS-1];
  assign quad.verts = vt[NS-1];
  assign quad.u0    = sat[NS-1][0] ? svt_pkg::UV_MAX : quo[NS-1][0];
  assign quad.u1    = sat[NS-1][1] ? svt_pkg::UV_MAX : quo[NS-1][1];
  assign quad.v0    = sat[NS-1][2] ? svt_pkg::UV_MAX : quo[NS-1][2];
  assign quad.v1    = sat[NS-1][3] ? svt_pkg::UV_MAX : quo[NS-1][3];

endmodule

### rtl/svt_back.sv
// Quad queue and vertex serializer: one vertex beat per cycle, four per quad.
module svt_back #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  svt_pkg::quad_t   in_quad,
  output logic             result_valid,
  output svt_pkg::result_t result
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  svt_pkg::quad_t   mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  svt_pkg::quad_t   cur;
  svt_pkg::corner_e corner;
  logic             active;
  logic             pop;

  assign pop = (count != '0) && (!active || corner == svt_pkg::CORNER_BL);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_quad;
    end
    if (pop) begin
      cur <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      active <= 1'b0;
      corner <= svt_pkg::CORNER_TL;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
      if (pop) begin
        active <= 1'b1;
      end else if (corner == svt_pkg::CORNER_BL) begin
        active <= 1'b0;
      end
      if (active) begin
        corner <= svt_pkg::corner_e'(corner + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    result.corner <= corner;
    result.vert_x <= cur.verts.vx[corner];
    result.vert_y <= cur.verts.vy[corner];
    result.tex_u  <= (corner == svt_pkg::CORNER_TL || corner == svt_pkg::CORNER_BL)
                     ? cur.u0 : cur.u1;
    result.tex_v  <= (corner == svt_pkg::CORNER_TL || corner == svt_pkg::CORNER_TR)
                     ? cur.v0 : cur.v1;
    result.last   <= (corner == svt_pkg::CORNER_BL);
  end

endmodule

### rtl/sprite_quad_vertex_transform.sv
// Top level of the sprite quad vertex transform: config registers, credit count, front, divider and back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------
//  item     | start, busy             | item (item_t)
//  result   | result_valid strobe     | result (result_t)
//  config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// Sustained throughput is set by the four vertex beats per quad at the output; the front takes
// a new rectangle before the last is through. From start, the first vertex passes 7 front
// stages, 17 divider stages, the queue and the output register. Up to QUEUE_DEPTH rectangles
// may be in flight; busy rises when that many are accepted and not fully emitted. Reset clears
// the pipeline and restores the register defaults. Results cannot be stalled.
module sprite_quad_vertex_transform #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  svt_pkg::item_t   item,
  output logic             result_valid,
  output svt_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  svt_pkg::cfg_t    cfg;
  logic [CW-1:0]    outstanding;
  logic             accept, retire;
  logic             f_valid, d_valid;
  svt_pkg::verts_t  f_verts;
  svt_pkg::div_in_t f_div [4];
  svt_pkg::quad_t   d_quad;

  assign cfg_ready = 1'b1;
  assign busy      = (outstanding == CW'(QUEUE_DEPTH));
  assign accept    = start && !busy;
  assign retire    = result_valid && result.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle    <= '0;
      cfg.rot_cx   <= '0;
      cfg.rot_cy   <= '0;
      cfg.scale_x  <= svt_pkg::SCALE_ONE;
      cfg.scale_y  <= svt_pkg::SCALE_ONE;
      cfg.origin_x <= '0;
      cfg.origin_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        svt_pkg::REG_ANGLE:    cfg.angle    <= cfg_data[15:0];
        svt_pkg::REG_ROT_CX:   cfg.rot_cx   <= cfg_data;
        svt_pkg::REG_ROT_CY:   cfg.rot_cy   <= cfg_data;
        svt_pkg::REG_SCALE_X:  cfg.scale_x  <= cfg_data[15:0];
        svt_pkg::REG_SCALE_Y:  cfg.scale_y  <= cfg_data[15:0];
        svt_pkg::REG_ORIGIN_X: cfg.origin_x <= cfg_data;
        svt_pkg::REG_ORIGIN_Y: cfg.origin_y <= cfg_data;
        default:               cfg.angle    <= cfg.angle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      case ({accept, retire})
        2'b10:   outstanding <= outstanding + 1'b1;
        2'b01:   outstanding <= outstanding - 1'b1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  svt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg       (cfg),
    .out_valid (f_valid),
    .verts     (f_verts),
    .div_in    (f_div)
  );

  svt_texdiv u_texdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .verts     (f_verts),
    .div_in    (f_div),
    .out_valid (d_valid),
    .quad      (d_quad)
  );

  svt_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .push         (d_valid),
    .in_quad      (d_quad),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
